// ===== sv/multichannel_blink_pulse_chase_driver_macros.svh =====
// Assertion macros for the multichannel blink/pulse/chase driver.
// Expects signals clk and rst_n in the scope that uses them.
`ifndef MULTICHANNEL_BLINK_PULSE_CHASE_DRIVER_MACROS_SVH
`define MULTICHANNEL_BLINK_PULSE_CHASE_DRIVER_MACROS_SVH

// Same-cycle implication.
`define MBPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mbpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the blink/pulse/chase driver.
// No dependencies.
package mbpc_pkg;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_IDLE   = 3'd1;
  localparam logic [2:0] REQ_ON     = 3'd2;
  localparam logic [2:0] REQ_BLINK  = 3'd3;
  localparam logic [2:0] REQ_PULSE  = 3'd4;
  localparam logic [2:0] REQ_CIRCLE = 3'd5;
  localparam logic [2:0] REQ_STROBE = 3'd6;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_BLINK  = 3'd2;
  localparam logic [2:0] MODE_PULSE  = 3'd3;
  localparam logic [2:0] MODE_CIRCLE = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [2:0]  op;
    logic [15:0] tv;
    logic [15:0] cwait;
  } cmd_t;

endpackage

// ===== sv/mbpc_cell.sv =====
`timescale 1ns / 1ps
// One channel cell: mode, level, stamp and wait of a single wire.
// Depends on mbpc_pkg; chained by the top level through token and light.
module mbpc_cell import mbpc_pkg::*; #(
  parameter logic IS_HEAD = 1'b0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tok_in,
  output logic        tok_out,
  input  logic        light_in,
  output logic        light_out,
  input  logic        sel,
  input  cmd_t        cmd,
  input  logic [31:0] now,
  output logic        level
);

  logic        tok_r;
  logic [2:0]  mode_r, mode_nxt;
  logic        level_r, level_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        elapsed;

  assign tok_out = tok_r;
  assign level   = level_r;
  assign elapsed = (now - stamp_r) >= {16'd0, wait_r};

  always_comb begin
    mode_nxt  = mode_r;
    level_nxt = level_r;
    stamp_nxt = stamp_r;
    wait_nxt  = wait_r;
    light_out = 1'b0;
    if (tok_r) begin
      case (mode_r)
        MODE_BLINK: begin
          if (elapsed) begin
            level_nxt = ~level_r;
            stamp_nxt = now;
          end
        end
        MODE_PULSE: begin
          if (elapsed) begin
            level_nxt = 1'b0;
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_CIRCLE: begin
          if (level_r && elapsed) begin
            level_nxt = 1'b0;
            light_out = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (light_in) begin
      level_nxt = 1'b1;
      stamp_nxt = now;
    end
    if (cmd.valid) begin
      case (cmd.op)
        REQ_IDLE: begin
          if (sel) begin
            level_nxt = 1'b0;
            mode_nxt  = MODE_IDLE;
          end
        end
        REQ_ON: begin
          if (sel) begin
            level_nxt = 1'b1;
            mode_nxt  = MODE_ON;
          end
        end
        REQ_BLINK, REQ_PULSE: begin
          if (sel) begin
            level_nxt = 1'b1;
            mode_nxt  = (cmd.op == REQ_BLINK) ? MODE_BLINK : MODE_PULSE;
            stamp_nxt = now;
            wait_nxt  = cmd.tv;
          end
        end
        REQ_CIRCLE: begin
          mode_nxt  = MODE_CIRCLE;
          level_nxt = IS_HEAD;
          wait_nxt  = cmd.cwait;
          if (IS_HEAD) begin
            stamp_nxt = now;
          end
        end
        REQ_STROBE: begin
          level_nxt = 1'b1;
          mode_nxt  = MODE_BLINK;
          stamp_nxt = now;
          wait_nxt  = cmd.tv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      mode_r  <= MODE_IDLE;
      level_r <= 1'b0;
    end else begin
      tok_r   <= tok_in;
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
    wait_r  <= wait_nxt;
  end

endmodule

// ===== sv/multichannel_blink_pulse_chase_driver.sv =====
`timescale 1ns / 1ps
// Multichannel blink/pulse/chase driver.
// Request channel: start, busy, in_req_type, in_channel, in_time_value.
//   A request is taken at a clock edge with start high and busy low.
// Result channel: out_valid strobes for one cycle with out_wire_levels,
//   one result per request; the receiver cannot stall it.
// Commands (idle, on, blink, pulse, circle, strobe, unknown code) update
//   the channel cells at the request edge, the result follows next cycle
//   and busy stays low: one command per cycle while no tick walk runs.
// A tick advances the time counter and sends a token down the row of
//   CHANNELS cells, one cell per cycle; a chasing light moves to the next
//   cell at the edge its holder is examined. busy stays high while the
//   token walks; the result is registered as it leaves the last cell, at
//   the edge that drops busy, and no new request is taken before then.
// Reset (rst_n low, synchronous) clears the time counter, sets every
//   channel idle and low, and drops busy and out_valid.
// Only wires 0..31 are addressable and shown in out_wire_levels.
`include "multichannel_blink_pulse_chase_driver_macros.svh"
module multichannel_blink_pulse_chase_driver import mbpc_pkg::*; #(
  parameter int CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [4:0]  in_channel,
  input  logic [15:0] in_time_value,
  output logic        out_valid,
  output logic [31:0] out_wire_levels
);

  localparam int SH = 16 + $clog2(CHANNELS);
  localparam logic [16:0] RECIP =
    17'(((64'd1 << SH) + 64'(CHANNELS) - 64'd1) / 64'(CHANNELS));

  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] now_r, now_nxt;
  logic        accept, tick_go;
  logic [32:0] cw_prod;
  cmd_t        cmd;
  logic [CHANNELS-1:0] tok_vec, light_vec, lvl_vec, sel_vec;

  assign accept  = start && !busy_r;
  assign tick_go = accept && (in_req_type == REQ_TICK);
  assign cw_prod = {17'd0, in_time_value} * {16'd0, RECIP};

  always_comb begin
    cmd.valid = accept && (in_req_type != REQ_TICK);
    cmd.op    = in_req_type;
    cmd.tv    = in_time_value;
    cmd.cwait = 16'(cw_prod >> SH);
  end

  always_comb begin
    now_nxt       = tick_go ? now_r + 32'd1 : now_r;
    busy_nxt      = tick_go ? 1'b1 : (tok_vec[CHANNELS-1] ? 1'b0 : busy_r);
    out_valid_nxt = cmd.valid || tok_vec[CHANNELS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= 32'd0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      now_r       <= now_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CHANNELS; i++) begin : g_cell
      if (i < 32) begin : g_sel
        assign sel_vec[i] = (in_channel == 5'(i));
      end else begin : g_nosel
        assign sel_vec[i] = 1'b0;
      end

      mbpc_cell #(
        .IS_HEAD (i == 0)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    ((i == 0) ? tick_go : tok_vec[(i + CHANNELS - 1) % CHANNELS]),
        .tok_out   (tok_vec[i]),
        .light_in  (light_vec[(i + CHANNELS - 1) % CHANNELS]),
        .light_out (light_vec[i]),
        .sel       (sel_vec[i]),
        .cmd       (cmd),
        .now       (now_r),
        .level     (lvl_vec[i])
      );
    end

    for (i = 0; i < 32; i++) begin : g_out
      if (i < CHANNELS) begin : g_lvl
        assign out_wire_levels[i] = lvl_vec[i];
      end else begin : g_zero
        assign out_wire_levels[i] = 1'b0;
      end
    end
  endgenerate

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `MBPC_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot0(tok_vec), "walk token not one-hot")
  `MBPC_ASSERT_NOW(a_busy_tok, 1'b1, busy_r == (|tok_vec), "busy out of step with walk")
  `MBPC_ASSERT_NEXT(a_tick_walk, tick_go, tok_vec[0] && busy_r, "tick did not start walk")
  `MBPC_ASSERT_NEXT(a_walk_done, tok_vec[CHANNELS-1], out_valid_r && !busy_r,
                    "walk end gave no result")

endmodule
